// File: rtl/core/argv_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// argv_pkg: shared types and constants of the argument splitter
// Item structs, character codes, result kinds, parse phases and the per-byte
// emission plan handed from the parser to the result sequencer.
// ----------------------------------------------------------------------------
package argv_pkg;

	localparam int RUN_W = 6;
	localparam logic [RUN_W-1:0] MAX_RUN = 6'd60;

	localparam logic [7:0] CH_QUOTE  = 8'h22;
	localparam logic [7:0] CH_BSLASH = 8'h5C;
	localparam logic [7:0] CH_SPACE  = 8'h20;
	localparam logic [7:0] CH_TAB    = 8'h09;

	localparam logic [1:0] KIND_BYTE     = 2'd0;
	localparam logic [1:0] KIND_END_ARG  = 2'd1;
	localparam logic [1:0] KIND_END_LINE = 2'd2;

	typedef struct packed {
		logic [7:0] in_byte;
		logic       in_last;
	} line_item_t;

	typedef struct packed {
		logic [7:0] out_byte;
		logic [1:0] out_kind;
		logic       run_clipped;
		logic       last_of_run;
	} arg_item_t;

	typedef enum logic [4:0] {
		PH_LEAD        = 5'b00001,
		PH_NAME_QUOTED = 5'b00010,
		PH_NAME_PLAIN  = 5'b00100,
		PH_GAP         = 5'b01000,
		PH_ARG         = 5'b10000
	} phase_t;

	// Results caused by one byte, in emission order:
	// leading backslashes, main result, trailing backslashes, end of arg, end of line.
	// Leading and trailing backslash runs never occur together, so they share cnt.
	typedef struct packed {
		logic [RUN_W-1:0] cnt;
		logic             cnt_tail;
		logic             main_vld;
		logic             main_end;
		logic [7:0]       main_byte;
		logic             tend;
		logic             eol;
		logic             clip;
	} plan_t;

endpackage
`default_nettype wire

// File: rtl/core/command_line_argv_splitter.sv
`default_nettype none
// ----------------------------------------------------------------------------
// command_line_argv_splitter: streaming command line argument splitter
// Splits a command line into argument bytes and end-of-argument /
// end-of-line markers following the usual quoting and backslash rules.
// ----------------------------------------------------------------------------
// One command line byte is taken per transfer on the line channel. The byte
// is decoded in the cycle it is accepted; the results it causes then leave one
// per cycle while arg_stall is low, through a single output register, with one
// shared down counter replaying held backslash runs. A byte with no result
// frees the input the next cycle; a byte with results keeps line_stall high
// until its last result is emitted, and causes at most 63 results, for a final
// byte closing a 60-backslash run. Backslash runs longer than 60 are clipped and
// reported on the end-of-line result.
module command_line_argv_splitter import argv_pkg::*; (
	input  wire        clk,
	input  wire        arst_n,
	input  wire        line_valid,
	output logic       line_stall,
	input  line_item_t line_item,
	output logic       arg_valid,
	input  wire        arg_stall,
	output arg_item_t  arg_item
);

	typedef enum logic [5:0] {
		ST_IDLE = 6'b000001,
		ST_PRE  = 6'b000010,
		ST_MAIN = 6'b000100,
		ST_TAIL = 6'b001000,
		ST_TEND = 6'b010000,
		ST_EOL  = 6'b100000
	} step_t;

	function automatic step_t pick_step(
		input logic [RUN_W-1:0] cnt,
		input logic             cnt_tail,
		input logic             main_vld,
		input logic             tend,
		input logic             eol
	);
		step_t s;
		priority if (cnt != '0 && !cnt_tail) s = ST_PRE;
		else if (main_vld)                    s = ST_MAIN;
		else if (cnt != '0)                   s = ST_TAIL;
		else if (tend)                        s = ST_TEND;
		else if (eol)                         s = ST_EOL;
		else                                  s = ST_IDLE;
		return s;
	endfunction

	plan_t            plan;
	logic             take;
	logic             emit;
	step_t            step_q, step_nx;
	logic [RUN_W-1:0] cnt_q, cnt_nx;
	logic             cnt_tail_q;
	logic             main_q, main_nx;
	logic             main_end_q;
	logic [7:0]       main_byte_q;
	logic             tend_q, tend_nx;
	logic             eol_q, eol_nx;
	logic             clip_q;
	logic             res_valid_q;
	arg_item_t        res_q;
	arg_item_t        res_nx;

	assign line_stall = (step_q != ST_IDLE);
	assign take       = line_valid && !line_stall;
	assign emit       = (step_q != ST_IDLE) && (!res_valid_q || !arg_stall);

	argv_parse u_parse (
		.clk    (clk),
		.arst_n (arst_n),
		.take   (take),
		.item   (line_item),
		.plan   (plan)
	);

	always_comb begin
		res_nx  = '0;
		cnt_nx  = cnt_q;
		main_nx = main_q;
		tend_nx = tend_q;
		eol_nx  = eol_q;
		unique case (step_q)
			ST_PRE, ST_TAIL: begin
				res_nx.out_byte = CH_BSLASH;
				res_nx.out_kind = KIND_BYTE;
				cnt_nx          = cnt_q - RUN_W'(1);
			end
			ST_MAIN: begin
				res_nx.out_byte = main_end_q ? 8'h00 : main_byte_q;
				res_nx.out_kind = main_end_q ? KIND_END_ARG : KIND_BYTE;
				main_nx         = 1'b0;
			end
			ST_TEND: begin
				res_nx.out_kind = KIND_END_ARG;
				tend_nx         = 1'b0;
			end
			ST_EOL: begin
				res_nx.out_kind    = KIND_END_LINE;
				res_nx.run_clipped = clip_q;
				eol_nx             = 1'b0;
			end
			default: begin
			end
		endcase
		step_nx            = pick_step(cnt_nx, cnt_tail_q, main_nx, tend_nx, eol_nx);
		res_nx.last_of_run = (step_nx == ST_IDLE);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q      <= ST_IDLE;
			cnt_q       <= '0;
			cnt_tail_q  <= 1'b0;
			main_q      <= 1'b0;
			tend_q      <= 1'b0;
			eol_q       <= 1'b0;
			res_valid_q <= 1'b0;
		end else begin
			if (take) begin
				step_q     <= pick_step(plan.cnt, plan.cnt_tail, plan.main_vld,
					plan.tend, plan.eol);
				cnt_q      <= plan.cnt;
				cnt_tail_q <= plan.cnt_tail;
				main_q     <= plan.main_vld;
				tend_q     <= plan.tend;
				eol_q      <= plan.eol;
			end else if (emit) begin
				step_q  <= step_nx;
				cnt_q   <= cnt_nx;
				main_q  <= main_nx;
				tend_q  <= tend_nx;
				eol_q   <= eol_nx;
			end
			if (emit) begin
				res_valid_q <= 1'b1;
			end else if (!arg_stall) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (take) begin
			main_end_q  <= plan.main_end;
			main_byte_q <= plan.main_byte;
			clip_q      <= plan.clip;
		end
		if (emit) begin
			res_q <= res_nx;
		end
	end

	assign arg_valid = res_valid_q;
	assign arg_item  = res_q;

endmodule
`default_nettype wire

// File: rtl/core/argv_parse.sv
`default_nettype none
// ----------------------------------------------------------------------------
// argv_parse: command line parse state
// Holds the parse phase, quoting and backslash state, and works out the
// emission plan for the byte offered on the input channel.
// ----------------------------------------------------------------------------
module argv_parse import argv_pkg::*; (
	input  wire        clk,
	input  wire        arst_n,
	input  wire        take,
	input  line_item_t item,
	output plan_t      plan
);

	phase_t           phase_q, phase_nx;
	logic             quoting_q, quoting_nx;
	logic             qpend_q, qpend_nx;
	logic [RUN_W-1:0] run_q, run_nx;
	logic             clip_q, clip_nx;

	always_comb begin
		logic [7:0]       c;
		logic             is_bs;
		logic             is_q;
		logic             blank;
		logic             do_arg;
		logic             do_plain;
		logic [RUN_W-1:0] n;

		c        = item.in_byte;
		is_bs    = (c == CH_BSLASH);
		is_q     = (c == CH_QUOTE);
		blank    = (c == CH_SPACE) || (c == CH_TAB);
		do_arg   = 1'b0;
		do_plain = 1'b0;
		n        = run_q;

		plan       = '0;
		phase_nx   = phase_q;
		quoting_nx = quoting_q;
		qpend_nx   = qpend_q;
		run_nx     = run_q;
		clip_nx    = clip_q;

		unique case (phase_q)
			PH_NAME_QUOTED: begin
				plan.main_vld = 1'b1;
				if (is_q) begin
					plan.main_end = 1'b1;
					phase_nx      = PH_GAP;
				end else begin
					plan.main_byte = c;
				end
			end
			PH_NAME_PLAIN: begin
				plan.main_vld = 1'b1;
				if (blank) begin
					plan.main_end = 1'b1;
					phase_nx      = PH_GAP;
				end else begin
					plan.main_byte = c;
				end
			end
			PH_GAP: begin
				if (!blank) begin
					phase_nx   = PH_ARG;
					quoting_nx = 1'b0;
					qpend_nx   = 1'b0;
					run_nx     = '0;
					do_arg     = 1'b1;
				end
			end
			PH_ARG: begin
				do_arg = 1'b1;
			end
			default: begin
				if (blank) begin
					phase_nx = PH_LEAD;
				end else if (is_q) begin
					phase_nx = PH_NAME_QUOTED;
				end else begin
					phase_nx       = PH_NAME_PLAIN;
					plan.main_vld  = 1'b1;
					plan.main_byte = c;
				end
			end
		endcase

		if (do_arg) begin
			n = run_nx;
			if (run_nx != '0) begin
				if (is_bs) begin
					// saturate the run and flag the drop
					if (run_nx < MAX_RUN) begin
						run_nx = run_nx + RUN_W'(1);
					end else begin
						clip_nx = 1'b1;
					end
				end else begin
					run_nx = '0;
					if (is_q) begin
						plan.cnt = n >> 1;
						if (n[0]) begin
							plan.main_vld  = 1'b1;
							plan.main_byte = CH_QUOTE;
						end else begin
							do_plain = 1'b1;
						end
					end else begin
						plan.cnt = n;
						do_plain = 1'b1;
					end
				end
			end else if (qpend_nx) begin
				qpend_nx = 1'b0;
				if (is_q) begin
					plan.main_vld  = 1'b1;
					plan.main_byte = CH_QUOTE;
				end else begin
					quoting_nx = 1'b0;
					do_plain   = 1'b1;
				end
			end else begin
				do_plain = 1'b1;
			end
		end

		if (do_plain) begin
			if (is_bs) begin
				run_nx = RUN_W'(1);
			end else if (is_q) begin
				if (quoting_nx) begin
					qpend_nx = 1'b1;
				end else begin
					quoting_nx = 1'b1;
				end
			end else if (!quoting_nx && blank) begin
				plan.main_vld = 1'b1;
				plan.main_end = 1'b1;
				phase_nx      = PH_GAP;
				quoting_nx    = 1'b0;
			end else begin
				plan.main_vld  = 1'b1;
				plan.main_byte = c;
			end
		end

		if (item.in_last) begin
			if (phase_nx == PH_NAME_QUOTED || phase_nx == PH_NAME_PLAIN) begin
				plan.tend = 1'b1;
			end else if (phase_nx == PH_ARG) begin
				// held backslashes go out literally; no leading run is possible here
				if (run_nx != '0) begin
					plan.cnt      = run_nx;
					plan.cnt_tail = 1'b1;
				end
				plan.tend = 1'b1;
			end
			plan.eol   = 1'b1;
			plan.clip  = clip_nx;
			phase_nx   = PH_LEAD;
			quoting_nx = 1'b0;
			qpend_nx   = 1'b0;
			run_nx     = '0;
			clip_nx    = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q   <= PH_LEAD;
			quoting_q <= 1'b0;
			qpend_q   <= 1'b0;
			run_q     <= '0;
			clip_q    <= 1'b0;
		end else if (take) begin
			phase_q   <= phase_nx;
			quoting_q <= quoting_nx;
			qpend_q   <= qpend_nx;
			run_q     <= run_nx;
			clip_q    <= clip_nx;
		end
	end

endmodule
`default_nettype wire

// File: rtl/core/argv_checker.sv
`default_nettype none
// ----------------------------------------------------------------------------
// argv_checker: port-level checks for the argument splitter
// Watches the ports of the top level and flags result sequences the
// splitter must never show.
// ----------------------------------------------------------------------------
module argv_checker import argv_pkg::*; (
	input wire        clk,
	input wire        arst_n,
	input wire        line_stall,
	input wire        arg_valid,
	input wire        arg_stall,
	input arg_item_t  arg_item
);

	// hold a stalled result
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		arg_valid && arg_stall |=> arg_valid && $stable(arg_item))
		else $error("stalled result changed");

	a_eol_last: assert property (@(posedge clk) disable iff (!arst_n)
		arg_valid && arg_item.out_kind == KIND_END_LINE |-> arg_item.last_of_run)
		else $error("end of line is not the final result of its byte");

	a_clip_eol: assert property (@(posedge clk) disable iff (!arst_n)
		arg_valid && arg_item.out_kind != KIND_END_LINE |-> !arg_item.run_clipped)
		else $error("clip flag outside end of line");

	a_marker_zero: assert property (@(posedge clk) disable iff (!arst_n)
		arg_valid && arg_item.out_kind != KIND_BYTE |-> arg_item.out_byte == 8'h00)
		else $error("marker carries a nonzero byte");

	// more results of the same byte pending: input must be held off
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		arg_valid && !arg_stall && !arg_item.last_of_run |-> line_stall)
		else $error("input open while results of a byte remain");

endmodule

bind command_line_argv_splitter argv_checker u_argv_checker (.*);
`default_nettype wire
